/* sv/mlrq_pkg.sv */
package mlrq_pkg;

    localparam int DEF_NUM_LEVELS      = 7;
    localparam int DEF_SLOTS_PER_LEVEL = 20;
    localparam int DEF_ID_BITS         = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_GET_NEXT  = 3'd2,
        OP_FIND      = 3'd3,
        OP_SET_READY = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NONE      = 3'd2,
        ST_WAITING   = 3'd3,
        ST_BAD_LEVEL = 3'd4
    } status_t;

    // which fields a result carries besides its status
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_SLOT,
        RES_FOUND,
        RES_TAKEN
    } res_src_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUSH,
        S_READ,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mem_rd;
        logic     slot_inc;
        logic     push_wr;
        logic     clr_valid;
        logic     set_wr;
        logic     shift_wr;
        logic     hit_set;
        logic     set_res;
        status_t  res_status;
        res_src_t res_src;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic bad_level;
        logic cur_valid;
        logic match;
        logic rd_ready;
        logic slot_last;
        logic lvl_last;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/mlrq_datapath.sv */
module mlrq_datapath #(
    parameter int NUM_LEVELS      = mlrq_pkg::DEF_NUM_LEVELS,
    parameter int SLOTS_PER_LEVEL = mlrq_pkg::DEF_SLOTS_PER_LEVEL,
    parameter int ID_BITS         = mlrq_pkg::DEF_ID_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [mlrq_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mlrq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  mlrq_pkg::dp_cmd_t                  cmd,
    output mlrq_pkg::dp_stat_t                 stat
);

    localparam int TotalSlots = NUM_LEVELS * SLOTS_PER_LEVEL;
    localparam int AW = (TotalSlots > 1) ? $clog2(TotalSlots) : 1;
    localparam int SW = $clog2(SLOTS_PER_LEVEL);
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int EW = ID_BITS + 1;

    mlrq_pkg::op_t     in_op;
    logic [2:0]        in_level;
    logic [7:0]        in_id;
    logic              in_rdy;

    mlrq_pkg::op_t     op_reg;
    logic [2:0]        level_reg;
    logic [ID_BITS-1:0] id_reg;
    logic              rdy_reg;
    logic [LW-1:0]     lvl_cnt_reg;
    logic [SW-1:0]     slot_cnt_reg;
    logic              hit_reg;

    logic [TotalSlots-1:0] valid_reg;
    logic [EW-1:0]     slot_mem [TotalSlots];
    logic [EW-1:0]     rd_reg;

    logic [AW-1:0]     addr;
    logic [AW-1:0]     prev_addr;
    logic [ID_BITS-1:0] rd_task;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;

    mlrq_pkg::status_t res_status_reg;
    logic [7:0]        res_id_reg;
    logic [2:0]        res_lvl_reg;
    logic [4:0]        res_slot_reg;

    logic              m_tvalid_reg;
    logic [mlrq_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    assign in_op    = mlrq_pkg::op_t'(s_tdata[2:0]);
    assign in_level = s_tdata[5:3];
    assign in_id    = s_tdata[13:6];
    assign in_rdy   = s_tdata[14];

    assign addr      = AW'(int'(lvl_cnt_reg) * SLOTS_PER_LEVEL + int'(slot_cnt_reg));
    assign prev_addr = addr - AW'(1);
    assign rd_task   = rd_reg[EW-1:1];

    // item registers and scan counters
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_op;
            level_reg    <= in_level;
            id_reg       <= ID_BITS'(in_id);
            rdy_reg      <= in_rdy;
            slot_cnt_reg <= '0;
            if (in_op == mlrq_pkg::OP_PUSH || in_op == mlrq_pkg::OP_GET_NEXT) begin
                lvl_cnt_reg <= LW'(in_level);
            end else begin
                lvl_cnt_reg <= '0;
            end
        end else if (cmd.slot_inc) begin
            if (slot_cnt_reg == SW'(SLOTS_PER_LEVEL - 1)) begin
                slot_cnt_reg <= '0;
                lvl_cnt_reg  <= lvl_cnt_reg + LW'(1);
            end else begin
                slot_cnt_reg <= slot_cnt_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_reg <= 1'b0;
        end else if (cmd.hit_set) begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.push_wr) begin
                valid_reg[addr] <= 1'b1;
            end
            if (cmd.shift_wr) begin
                valid_reg[prev_addr] <= valid_reg[addr];
            end
            if (cmd.clr_valid) begin
                valid_reg[addr] <= 1'b0;
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr;
        wr_data = {id_reg, rdy_reg};
        if (cmd.push_wr) begin
            wr_en = 1'b1;
        end else if (cmd.set_wr) begin
            wr_en   = 1'b1;
            wr_data = {rd_task, rdy_reg};
        end else if (cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = prev_addr;
            wr_data = rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_reg <= slot_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_src)
                mlrq_pkg::RES_SLOT: begin
                    res_id_reg   <= '0;
                    res_lvl_reg  <= '0;
                    res_slot_reg <= 5'(slot_cnt_reg);
                end
                mlrq_pkg::RES_FOUND: begin
                    res_id_reg   <= 8'(rd_task);
                    res_lvl_reg  <= 3'(lvl_cnt_reg);
                    res_slot_reg <= 5'(slot_cnt_reg);
                end
                mlrq_pkg::RES_TAKEN: begin
                    res_id_reg   <= 8'(rd_task);
                    res_lvl_reg  <= '0;
                    res_slot_reg <= 5'(slot_cnt_reg);
                end
                default: begin
                    res_id_reg   <= '0;
                    res_lvl_reg  <= '0;
                    res_slot_reg <= '0;
                end
            endcase
        end
    end

    // output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {5'b0, res_slot_reg, res_lvl_reg, res_id_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.op        = op_reg;
    assign stat.bad_level = int'(level_reg) >= NUM_LEVELS;
    assign stat.cur_valid = valid_reg[addr];
    assign stat.match     = valid_reg[addr] && (rd_task == id_reg);
    assign stat.rd_ready  = rd_reg[0];
    assign stat.slot_last = slot_cnt_reg == SW'(SLOTS_PER_LEVEL - 1);
    assign stat.lvl_last  = lvl_cnt_reg == LW'(NUM_LEVELS - 1);
    assign stat.hit       = hit_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

endmodule

/* sv/mlrq_ctrl.sv */
module mlrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mlrq_pkg::dp_stat_t  stat,
    output mlrq_pkg::dp_cmd_t   cmd
);

    mlrq_pkg::state_t state_reg;
    mlrq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlrq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = mlrq_pkg::ST_NONE;
        cmd.res_src    = mlrq_pkg::RES_ZERO;
        s_tready       = 1'b0;

        unique case (state_reg)
            mlrq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = mlrq_pkg::S_DISPATCH;
                end
            end

            mlrq_pkg::S_DISPATCH: begin
                unique case (stat.op) inside
                    mlrq_pkg::OP_PUSH, mlrq_pkg::OP_GET_NEXT: begin
                        if (stat.bad_level) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = mlrq_pkg::ST_BAD_LEVEL;
                            state_next     = mlrq_pkg::S_FINISH;
                        end else if (stat.op == mlrq_pkg::OP_PUSH) begin
                            state_next = mlrq_pkg::S_PUSH;
                        end else begin
                            state_next = mlrq_pkg::S_READ;
                        end
                    end
                    mlrq_pkg::OP_REMOVE, mlrq_pkg::OP_FIND, mlrq_pkg::OP_SET_READY: begin
                        state_next = mlrq_pkg::S_READ;
                    end
                    default: begin
                        cmd.set_res = 1'b1;
                        state_next  = mlrq_pkg::S_FINISH;
                    end
                endcase
            end

            // valid bits sit in flops, so push needs no memory read
            mlrq_pkg::S_PUSH: begin
                if (!stat.cur_valid) begin
                    cmd.push_wr    = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_status = mlrq_pkg::ST_OK;
                    cmd.res_src    = mlrq_pkg::RES_SLOT;
                    state_next     = mlrq_pkg::S_FINISH;
                end else if (stat.slot_last) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = mlrq_pkg::ST_FULL;
                    state_next     = mlrq_pkg::S_FINISH;
                end else begin
                    cmd.slot_inc = 1'b1;
                end
            end

            mlrq_pkg::S_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = mlrq_pkg::S_CHECK;
            end

            mlrq_pkg::S_CHECK: begin
                case (stat.op) inside
                    mlrq_pkg::OP_REMOVE, mlrq_pkg::OP_SET_READY: begin
                        if (stat.match) begin
                            cmd.hit_set = 1'b1;
                            if (stat.op == mlrq_pkg::OP_REMOVE) begin
                                cmd.clr_valid = 1'b1;
                            end else begin
                                cmd.set_wr = 1'b1;
                            end
                        end
                        if (stat.slot_last && stat.lvl_last) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = (stat.hit || stat.match) ?
                                             mlrq_pkg::ST_OK : mlrq_pkg::ST_NONE;
                            state_next     = mlrq_pkg::S_FINISH;
                        end else begin
                            cmd.slot_inc = 1'b1;
                            state_next   = mlrq_pkg::S_READ;
                        end
                    end
                    mlrq_pkg::OP_FIND: begin
                        if (stat.match) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = mlrq_pkg::ST_OK;
                            cmd.res_src    = mlrq_pkg::RES_FOUND;
                            state_next     = mlrq_pkg::S_FINISH;
                        end else if (stat.slot_last && stat.lvl_last) begin
                            cmd.set_res = 1'b1;
                            state_next  = mlrq_pkg::S_FINISH;
                        end else begin
                            cmd.slot_inc = 1'b1;
                            state_next   = mlrq_pkg::S_READ;
                        end
                    end
                    mlrq_pkg::OP_GET_NEXT: begin
                        if (!stat.cur_valid) begin
                            cmd.set_res = 1'b1;
                            state_next  = mlrq_pkg::S_FINISH;
                        end else if (stat.rd_ready) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = mlrq_pkg::ST_OK;
                            cmd.res_src    = mlrq_pkg::RES_TAKEN;
                            if (stat.slot_last) begin
                                cmd.clr_valid = 1'b1;
                                state_next    = mlrq_pkg::S_FINISH;
                            end else begin
                                cmd.slot_inc = 1'b1;
                                state_next   = mlrq_pkg::S_SHIFT_RD;
                            end
                        end else if (stat.slot_last) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = mlrq_pkg::ST_WAITING;
                            state_next     = mlrq_pkg::S_FINISH;
                        end else begin
                            cmd.slot_inc = 1'b1;
                            state_next   = mlrq_pkg::S_READ;
                        end
                    end
                    default: begin
                        state_next = mlrq_pkg::S_FINISH;
                    end
                endcase
            end

            // move each later slot down by one; clear the last slot at the end
            mlrq_pkg::S_SHIFT_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = mlrq_pkg::S_SHIFT_WR;
            end

            mlrq_pkg::S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                if (stat.slot_last) begin
                    cmd.clr_valid = 1'b1;
                    state_next    = mlrq_pkg::S_FINISH;
                end else begin
                    cmd.slot_inc = 1'b1;
                    state_next   = mlrq_pkg::S_SHIFT_RD;
                end
            end

            mlrq_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = mlrq_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = mlrq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/multilevel_ready_queue.sv */
// Channel   Direction  Ports                          tdata fields (lowest bit up)
// s_        in         s_tvalid s_tready s_tdata[15:0] cmd[2:0] level[5:3]
//                                                     task_id[13:6] ready_flag[14]
// m_        out        m_tvalid m_tready m_tdata[23:0] status[2:0] out_id[10:3]
//                                                     out_level[13:11] out_slot[18:14]
//
// One command at a time. Each slot visited takes a memory read (S_READ) and then
// a compare (S_CHECK) on the slot memory; push tests the flop valid bits slot by
// slot in S_PUSH. Remove and set_ready visit all NUM_LEVELS*SLOTS_PER_LEVEL slots.
// Get_next, on a take, moves each later slot down with a read (S_SHIFT_RD) and then
// a write (S_SHIFT_WR).
// Reset empties every slot at once; no clearing pass. A result waiting on
// m_tready holds the block in its last step but not the next input transfer.
module multilevel_ready_queue #(
    parameter int NUM_LEVELS      = mlrq_pkg::DEF_NUM_LEVELS,
    parameter int SLOTS_PER_LEVEL = mlrq_pkg::DEF_SLOTS_PER_LEVEL,
    parameter int ID_BITS         = mlrq_pkg::DEF_ID_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd, level, task_id, ready_flag
    input  logic [mlrq_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, out_id, out_level, out_slot
    output logic [mlrq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    mlrq_pkg::dp_cmd_t  cmd;
    mlrq_pkg::dp_stat_t stat;

    mlrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlrq_datapath #(
        .NUM_LEVELS      (NUM_LEVELS),
        .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
        .ID_BITS         (ID_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* bench/tb_multilevel_ready_queue.sv */
`timescale 1ns / 1ps

module tb_multilevel_ready_queue;
    import mlrq_pkg::*;

    localparam int LEVELS = DEF_NUM_LEVELS;
    localparam int SLOTS  = DEF_SLOTS_PER_LEVEL;
    localparam int TOTAL  = LEVELS * SLOTS;

    // command codes with no operation behind them
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam logic [2:0] LVL_BAD   = 3'd7;

    localparam int RANDOM_CMDS = 1850;
    localparam int TAIL_CYCLES = 400;

    // fields from the lowest bit up: cmd, level, task_id, ready_flag
    typedef struct packed {
        logic       ready_flag;
        logic [7:0] task_id;
        logic [2:0] level;
        logic [2:0] cmd;
    } sched_cmd_t;

    // fields from the lowest bit up: status, out_id, out_level, out_slot
    typedef struct packed {
        logic [4:0] out_slot;
        logic [2:0] out_level;
        logic [7:0] out_id;
        status_t    status;
    } sched_res_t;

    typedef struct {
        bit         typed;
        sched_res_t res;
    } res_note_t;

    typedef struct {
        sched_cmd_t c;
        int         reps;
        bit         typed;
        sched_res_t res;
    } dir_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int idle_pct  = 0;
    int stall_pct = 0;
    int n_err     = 0;

    // shadow of the slot table
    bit         q_valid[TOTAL];
    logic [7:0] q_task[TOTAL];
    bit         q_ready[TOTAL];

    sched_res_t pending_res[$];
    res_note_t  typed_q[$];
    dir_row_t   dir_tab[$];

    multilevel_ready_queue #(
        .NUM_LEVELS      (DEF_NUM_LEVELS),
        .SLOTS_PER_LEVEL (DEF_SLOTS_PER_LEVEL),
        .ID_BITS         (DEF_ID_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic sched_res_t schedule_cmd(sched_cmd_t c);
        sched_res_t r;
        int base, k, s, i;
        bit hit;
        r = '0;
        r.status = ST_NONE;
        hit = 1'b0;
        base = int'(c.level) * SLOTS;
        case (c.cmd)
            OP_PUSH: begin
                if (c.level >= LEVELS) begin
                    r.status = ST_BAD_LEVEL;
                end else begin
                    r.status = ST_FULL;
                    for (s = 0; s < SLOTS; s++) begin
                        if (!q_valid[base + s]) begin
                            q_valid[base + s] = 1'b1;
                            q_task[base + s]  = c.task_id;
                            q_ready[base + s] = c.ready_flag;
                            r.status   = ST_OK;
                            r.out_slot = 5'(s);
                            break;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                for (k = 0; k < TOTAL; k++) begin
                    if (q_valid[k] && q_task[k] == c.task_id) begin
                        q_valid[k] = 1'b0;
                        hit = 1'b1;
                    end
                end
                r.status = hit ? ST_OK : ST_NONE;
            end
            OP_GET_NEXT: begin
                if (c.level >= LEVELS) begin
                    r.status = ST_BAD_LEVEL;
                end else begin
                    r.status = ST_WAITING;
                    for (s = 0; s < SLOTS; s++) begin
                        k = base + s;
                        if (!q_valid[k]) begin
                            r.status = ST_NONE;
                            break;
                        end
                        if (q_ready[k]) begin
                            r.status   = ST_OK;
                            r.out_id   = q_task[k];
                            r.out_slot = 5'(s);
                            // close the gap, then empty the last slot
                            for (i = k; i < base + SLOTS - 1; i++) begin
                                q_valid[i] = q_valid[i + 1];
                                q_task[i]  = q_task[i + 1];
                                q_ready[i] = q_ready[i + 1];
                            end
                            q_valid[base + SLOTS - 1] = 1'b0;
                            q_task[base + SLOTS - 1]  = '0;
                            q_ready[base + SLOTS - 1] = 1'b0;
                            break;
                        end
                    end
                end
            end
            OP_FIND: begin
                for (k = 0; k < TOTAL; k++) begin
                    if (q_valid[k] && q_task[k] == c.task_id) begin
                        r.status    = ST_OK;
                        r.out_id    = c.task_id;
                        r.out_level = 3'(k / SLOTS);
                        r.out_slot  = 5'(k % SLOTS);
                        break;
                    end
                end
            end
            OP_SET_READY: begin
                for (k = 0; k < TOTAL; k++) begin
                    if (q_valid[k] && q_task[k] == c.task_id) begin
                        q_ready[k] = c.ready_flag;
                        hit = 1'b1;
                    end
                end
                r.status = hit ? ST_OK : ST_NONE;
            end
            default: r.status = ST_NONE;
        endcase
        return r;
    endfunction

    task automatic report_bad(string what, sched_res_t want, sched_res_t got);
        n_err++;
        if (n_err <= 10)
            $display("%0t %s: want st=%0d id=%0d lvl=%0d slot=%0d, %s",
                     $time, what, want.status, want.out_id, want.out_level, want.out_slot,
                     $sformatf("got st=%0d id=%0d lvl=%0d slot=%0d",
                               got.status, got.out_id, got.out_level, got.out_slot));
    endtask

    task automatic dir_row(logic [2:0] op, logic [2:0] lvl, logic [7:0] id, logic rdy,
                           int reps, bit typed, status_t st = ST_OK,
                           logic [7:0] oid = '0, logic [2:0] olvl = '0, logic [4:0] oslot = '0);
        dir_row_t row;
        row.c.cmd          = op;
        row.c.level        = lvl;
        row.c.task_id      = id;
        row.c.ready_flag   = rdy;
        row.reps           = reps;
        row.typed          = typed;
        row.res.status     = st;
        row.res.out_id     = oid;
        row.res.out_level  = olvl;
        row.res.out_slot   = oslot;
        dir_tab.push_back(row);
    endtask

    // hold the command until its transfer, idling first at the current rate
    task automatic send_cmd(sched_cmd_t c, bit typed, sched_res_t res);
        res_note_t n;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        n.typed = typed;
        n.res   = res;
        typed_q.push_back(n);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c};
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin : watch
        sched_cmd_t c;
        sched_res_t want;
        sched_res_t got;
        res_note_t  n;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c    = s_tdata[14:0];
                want = schedule_cmd(c);
                n    = typed_q.pop_front();
                if (n.typed)
                    want = n.res;
                pending_res.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[18:0];
                if (pending_res.size() == 0) begin
                    report_bad("unexpected result", '0, got);
                end else begin
                    want = pending_res.pop_front();
                    if (got.status !== want.status || got.out_id !== want.out_id ||
                        got.out_level !== want.out_level || got.out_slot !== want.out_slot)
                        report_bad("result mismatch", want, got);
                end
            end
        end
    end

    initial begin : stim
        sched_cmd_t c;
        sched_res_t blank;
        int         ph, i, r, hot;
        blank = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, bad levels, reserved commands
        dir_row(OP_GET_NEXT,  3'd0,    8'h00, 1'b0, 1, 1, ST_NONE);
        dir_row(OP_FIND,      3'd0,    8'h00, 1'b0, 1, 1, ST_NONE);
        dir_row(OP_REMOVE,    LVL_BAD, 8'hFF, 1'b1, 1, 1, ST_NONE);
        dir_row(OP_SET_READY, 3'd0,    8'h5A, 1'b1, 1, 1, ST_NONE);
        dir_row(OP_PUSH,      LVL_BAD, 8'h33, 1'b1, 1, 1, ST_BAD_LEVEL);
        dir_row(OP_GET_NEXT,  LVL_BAD, 8'h00, 1'b0, 1, 1, ST_BAD_LEVEL);
        dir_row(CMD_RSVD5,    LVL_BAD, 8'hFF, 1'b1, 1, 1, ST_NONE);
        dir_row(CMD_RSVD6,    3'd0,    8'h00, 1'b0, 1, 1, ST_NONE);
        dir_row(CMD_RSVD7,    3'd5,    8'hC3, 1'b1, 1, 1, ST_NONE);
        // basic push, find, take, readiness and remove
        dir_row(OP_PUSH,      3'd0,    8'h00, 1'b0, 1, 1, ST_OK, 8'h00, 3'd0, 5'd0);
        dir_row(OP_PUSH,      3'd0,    8'hFF, 1'b1, 1, 1, ST_OK, 8'h00, 3'd0, 5'd1);
        dir_row(OP_PUSH,      3'd6,    8'hAA, 1'b0, 1, 1, ST_OK, 8'h00, 3'd0, 5'd0);
        dir_row(OP_FIND,      3'd3,    8'hAA, 1'b0, 1, 1, ST_OK, 8'hAA, 3'd6, 5'd0);
        dir_row(OP_GET_NEXT,  3'd0,    8'h00, 1'b0, 1, 1, ST_OK, 8'hFF, 3'd0, 5'd1);
        dir_row(OP_GET_NEXT,  3'd0,    8'h00, 1'b0, 1, 1, ST_NONE);
        dir_row(OP_SET_READY, 3'd2,    8'h00, 1'b1, 1, 1, ST_OK);
        dir_row(OP_GET_NEXT,  3'd0,    8'h00, 1'b0, 1, 1, ST_OK, 8'h00, 3'd0, 5'd0);
        dir_row(OP_GET_NEXT,  3'd6,    8'h00, 1'b0, 1, 1, ST_NONE);
        dir_row(OP_REMOVE,    3'd1,    8'hAA, 1'b0, 1, 1, ST_OK);
        dir_row(OP_FIND,      3'd6,    8'hAA, 1'b0, 1, 1, ST_NONE);
        // fill a level with waiting tasks, then take from the last slot
        dir_row(OP_PUSH,      3'd3,    8'h40, 1'b0, SLOTS, 0);
        dir_row(OP_PUSH,      3'd3,    8'h99, 1'b1, 1, 1, ST_FULL);
        dir_row(OP_GET_NEXT,  3'd3,    8'h00, 1'b0, 1, 1, ST_WAITING);
        dir_row(OP_SET_READY, 3'd0,    8'h53, 1'b1, 1, 1, ST_OK);
        dir_row(OP_GET_NEXT,  3'd3,    8'h00, 1'b0, 1, 1, ST_OK, 8'h53, 3'd0, 5'd19);
        dir_row(OP_PUSH,      3'd3,    8'h40, 1'b1, 1, 1, ST_OK, 8'h00, 3'd0, 5'd19);
        dir_row(OP_SET_READY, 3'd4,    8'h40, 1'b1, 1, 0);
        dir_row(OP_REMOVE,    3'd3,    8'h45, 1'b0, 1, 0);
        dir_row(OP_GET_NEXT,  3'd3,    8'h00, 1'b0, 1, 0);
        dir_row(OP_PUSH,      3'd3,    8'h77, 1'b0, 1, 0);
        dir_row(OP_REMOVE,    3'd0,    8'h40, 1'b0, 1, 0);

        foreach (dir_tab[d]) begin
            for (r = 0; r < dir_tab[d].reps; r++) begin
                c = dir_tab[d].c;
                c.task_id = c.task_id + 8'(r);
                send_cmd(c, dir_tab[d].typed, dir_tab[d].res);
            end
        end

        hot = 0;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (i = 0; i < RANDOM_CMDS / 4; i++) begin
                // move the busy level now and then so levels fill and drain
                if (i % 64 == 0)
                    hot = $urandom_range(LEVELS - 1);
                r = $urandom_range(99);
                if (r < 40)      c.cmd = OP_PUSH;
                else if (r < 65) c.cmd = OP_GET_NEXT;
                else if (r < 73) c.cmd = OP_REMOVE;
                else if (r < 85) c.cmd = OP_FIND;
                else if (r < 97) c.cmd = OP_SET_READY;
                else             c.cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
                r = $urandom_range(99);
                if (c.cmd != OP_PUSH && c.cmd != OP_GET_NEXT) c.level = 3'($urandom_range(7));
                else if (r < 6)                               c.level = LVL_BAD;
                else if (r < 55)                              c.level = 3'(hot);
                else                                          c.level = 3'($urandom_range(LEVELS - 1));
                // mostly a small pool of ids so that removes and finds hit
                if ($urandom_range(99) < 70) c.task_id = 8'($urandom_range(15));
                else                         c.task_id = 8'($urandom_range(255));
                c.ready_flag = 1'($urandom_range(1));
                send_cmd(c, 1'b0, blank);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_err == 0 && pending_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
